// File: design/tadc_pkg.sv
// ----------------------------------------------------------------------------
// tadc_pkg
// Types and constants shared by the turbidity averaging and scaling block.
// ----------------------------------------------------------------------------
package tadc_pkg;

  typedef struct packed {
    logic [11:0] sample;
    logic        sample_ok;
  } in_item_t;

  typedef struct packed {
    logic [11:0] raw_average;
    logic [12:0] vout_mv;
    logic [9:0]  ntu;
    logic        sat_warn;
    logic        log_tick;
  } out_item_t;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_SAT_HIGH   = 3'd1;
  localparam logic [2:0] CFG_SAT_LOW    = 3'd2;
  localparam logic [2:0] CFG_WARN_RUN   = 3'd3;
  localparam logic [2:0] CFG_LOG_PERIOD = 3'd4;

  localparam logic [11:0] RST_SAT_HIGH   = 12'd4080;
  localparam logic [11:0] RST_SAT_LOW    = 12'd15;
  localparam logic [15:0] RST_WARN_RUN   = 16'd20;
  localparam logic [7:0]  RST_LOG_PERIOD = 8'd30;

  // serial divider geometry
  localparam int unsigned DIV_W   = 26;
  localparam int unsigned DSR_W   = 13;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned NTU_DW  = 23;
  localparam int unsigned ITER_W  = 5;

  // scaling constants, full scale 4095 codes = 4.5 V
  localparam logic [13:0] VMV_GAIN      = 14'd9000;
  localparam logic [11:0] NTU_GAIN      = 12'd2250;
  localparam logic [11:0] ROUND_ADD     = 12'd4095;
  localparam logic [12:0] SCALE_DIVISOR = 13'd8190;
  localparam logic [11:0] FULL_SCALE    = 12'd4095;
  localparam logic [11:0] NTU_RAW_FLOOR = 12'd455;
  localparam logic [12:0] VMV_MIN       = 13'd500;
  localparam logic [12:0] VMV_MAX       = 13'd4500;
  localparam logic [9:0]  NTU_MAX       = 10'd1000;
  localparam logic [15:0] RUN_MAX       = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_SCALE,
    ST_DIV_VMV,
    ST_LOAD_NTU,
    ST_DIV_NTU,
    ST_DONE
  } state_t;

endpackage

// File: design/turbidity_adc_average_to_ntu_top.sv
// ----------------------------------------------------------------------------
// turbidity_adc_average_to_ntu_top
// Averages groups of ADC reads and scales the mean to millivolts and NTU.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | in_item_t  (sample, sample_ok)
//  out_    | output    | out_valid/out_stall| out_item_t (average, mV, NTU..)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  An item that does not close a group is taken without a stall.
//  A closing item with valid reads starts three passes of one restoring
//  divider, one quotient bit a cycle (15 + 26 + 23 steps), with the load
//  and capture states SCALE, LOAD_NTU and DONE; the input stalls till idle.
//  rst_n is synchronous; config is always ready and needs no clearing pass.
//  A stalled result waits in the output register while the block keeps
//  accepting; it only holds off when the next result is finished.
// ----------------------------------------------------------------------------
module turbidity_adc_average_to_ntu_top #(
  parameter int unsigned SAMPLES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tadc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tadc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import tadc_pkg::*;

  localparam logic [3:0] GROUP_LEN = 4'(SAMPLES);

  // configuration
  logic        enable_r;
  logic [11:0] sat_high_r;
  logic [11:0] sat_low_r;
  logic [15:0] warn_run_r;
  logic [7:0]  log_period_r;

  // accumulation state
  logic [SUM_W-1:0] sum_r;
  logic [2:0]       pos_r;
  logic [3:0]       cnt_r;
  logic [15:0]      high_run_r;
  logic [15:0]      low_run_r;
  logic [7:0]       phase_r;

  // serial divider
  logic [DIV_W-1:0]  shreg_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  divisor_r;
  logic [ITER_W-1:0] iter_r;

  logic [11:0] avg_r;
  logic [12:0] vmv_r;
  logic        warn_r;
  logic        tick_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  state_t state_r, state_nxt;

  logic        in_accept;
  logic        div_run;
  logic        out_load;
  logic        closing;
  logic [SUM_W-1:0] sum_nxt;
  logic [3:0]  cnt_nxt;

  // ---------------------------------------------------------------------------
  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      sat_high_r   <= RST_SAT_HIGH;
      sat_low_r    <= RST_SAT_LOW;
      warn_run_r   <= RST_WARN_RUN;
      log_period_r <= RST_LOG_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_SAT_HIGH:   sat_high_r   <= cfg_data[11:0];
        CFG_SAT_LOW:    sat_low_r    <= cfg_data[11:0];
        CFG_WARN_RUN:   warn_run_r   <= cfg_data;
        CFG_LOG_PERIOD: log_period_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_accept && enable_r && closing && (cnt_nxt != 4'd0))
                     state_nxt = ST_DIV_AVG;
      ST_DIV_AVG:  if (iter_r == ITER_W'(1)) state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_DIV_VMV;
      ST_DIV_VMV:  if (iter_r == ITER_W'(1)) state_nxt = ST_LOAD_NTU;
      ST_LOAD_NTU: state_nxt = ST_DIV_NTU;
      ST_DIV_NTU:  if (iter_r == ITER_W'(1)) state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    div_run  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_stall = 1'b0;
      ST_DIV_AVG, ST_DIV_VMV, ST_DIV_NTU: div_run = 1'b1;
      ST_DONE:    out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // group accumulation
  assign sum_nxt = in_data.sample_ok ? sum_r + SUM_W'(in_data.sample) : sum_r;
  assign cnt_nxt = in_data.sample_ok ? cnt_r + 4'd1 : cnt_r;
  assign closing = ({1'b0, pos_r} + 4'd1) >= GROUP_LEN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      pos_r <= '0;
      cnt_r <= '0;
    end else if (in_accept && enable_r) begin
      if (closing) begin
        sum_r <= '0;
        pos_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        pos_r <= pos_r + 3'd1;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // restoring divider step, dividend msb-first out of shreg, quotient in at lsb
  logic [DSR_W:0]   trial;
  logic             trial_ge;
  logic [DSR_W:0]   trial_diff;

  assign trial      = {rem_r, shreg_r[DIV_W-1]};
  assign trial_ge   = trial >= {1'b0, divisor_r};
  assign trial_diff = trial - {1'b0, divisor_r};

  // saturation runs and log phase, evaluated on the fresh average
  logic [11:0] avg_q;
  logic        hit_high, hit_low;
  logic [15:0] high_run_nxt, low_run_nxt;
  logic [7:0]  phase_inc;
  logic        tick_nxt;

  assign avg_q    = shreg_r[11:0];
  assign hit_high = avg_q >= sat_high_r;
  assign hit_low  = avg_q <= sat_low_r;
  assign high_run_nxt = !hit_high ? 16'd0 :
                        (high_run_r == RUN_MAX) ? RUN_MAX : high_run_r + 16'd1;
  assign low_run_nxt  = !hit_low ? 16'd0 :
                        (low_run_r == RUN_MAX) ? RUN_MAX : low_run_r + 16'd1;
  assign phase_inc = phase_r + 8'd1;
  assign tick_nxt  = phase_inc >= log_period_r;

  // scaling products, each from a register and registered into the divider
  logic [DIV_W-1:0]  vmv_dividend;
  logic [11:0]       ntu_raw;
  logic [11:0]       ntu_span;
  logic [NTU_DW-1:0] ntu_dividend;
  logic [12:0]       vmv_q;
  logic [12:0]       vmv_clamped;
  logic [9:0]        ntu_clamped;

  assign vmv_dividend = DIV_W'(avg_q) * DIV_W'(VMV_GAIN) + DIV_W'(ROUND_ADD);
  assign ntu_raw      = (avg_r < NTU_RAW_FLOOR) ? NTU_RAW_FLOOR : avg_r;
  assign ntu_span     = FULL_SCALE - ntu_raw;
  assign ntu_dividend = NTU_DW'(ntu_span) * NTU_DW'(NTU_GAIN) + NTU_DW'(ROUND_ADD);

  assign vmv_q       = shreg_r[12:0];
  assign vmv_clamped = (vmv_q < VMV_MIN) ? VMV_MIN :
                       (vmv_q > VMV_MAX) ? VMV_MAX : vmv_q;
  assign ntu_clamped = (shreg_r[NTU_DW-1:0] > NTU_DW'(NTU_MAX)) ? NTU_MAX :
                       shreg_r[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_run_r <= '0;
      low_run_r  <= '0;
      phase_r    <= '0;
      iter_r     <= '0;
    end else begin
      if (state_r == ST_IDLE && state_nxt == ST_DIV_AVG) begin
        iter_r <= ITER_W'(SUM_W);
      end else if (state_r == ST_SCALE) begin
        iter_r     <= ITER_W'(DIV_W);
        high_run_r <= high_run_nxt;
        low_run_r  <= low_run_nxt;
        phase_r    <= tick_nxt ? 8'd0 : phase_inc;
      end else if (state_r == ST_LOAD_NTU) begin
        iter_r <= ITER_W'(NTU_DW);
      end else if (div_run) begin
        iter_r <= iter_r - ITER_W'(1);
      end
    end
  end

  // divider and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      shreg_r   <= {sum_nxt, (DIV_W - SUM_W)'(0)};
      rem_r     <= '0;
      divisor_r <= DSR_W'(cnt_nxt);
    end else if (state_r == ST_SCALE) begin
      avg_r     <= avg_q;
      warn_r    <= (high_run_nxt == warn_run_r) || (low_run_nxt == warn_run_r);
      tick_r    <= tick_nxt;
      shreg_r   <= vmv_dividend;
      rem_r     <= '0;
      divisor_r <= SCALE_DIVISOR;
    end else if (state_r == ST_LOAD_NTU) begin
      vmv_r     <= vmv_clamped;
      shreg_r   <= {ntu_dividend, (DIV_W - NTU_DW)'(0)};
      rem_r     <= '0;
      divisor_r <= SCALE_DIVISOR;
    end else if (div_run) begin
      shreg_r <= {shreg_r[DIV_W-2:0], trial_ge};
      rem_r   <= trial_ge ? trial_diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.raw_average <= avg_r;
      out_data_r.vout_mv     <= vmv_r;
      out_data_r.ntu         <= ntu_clamped;
      out_data_r.sat_warn    <= warn_r;
      out_data_r.log_tick    <= tick_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_AVG || state_r == ST_DIV_VMV || state_r == ST_DIV_NTU)
      |-> iter_r != '0)
    else $error("divider running with an exhausted step count");

  a_vmv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.vout_mv >= VMV_MIN && out_data_r.vout_mv <= VMV_MAX
                     && out_data_r.ntu <= NTU_MAX))
    else $error("scaled result out of range");

  a_group_pos: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < GROUP_LEN)
    else $error("group position beyond group length");

endmodule
